/* src/atatf_pkg.sv */
// Shared constants and types for the ATA task-file command builder.
package atatf_pkg;

    // Field widths.
    localparam int BLK_W      = 32;
    localparam int TOTAL_W    = 9;
    localparam int BYTE_W     = 8;
    localparam int HEADS_W    = 5;
    localparam int PER_CYL_W  = HEADS_W + BYTE_W;
    localparam int CFG_IDX_W  = 2;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 72;

    // Largest transfer in sectors.
    localparam int MAX_SECTORS_DEF = 256;

    // Command and control codes.
    localparam logic [BYTE_W-1:0] OP_READ     = 8'h20;
    localparam logic [BYTE_W-1:0] OP_WRITE    = 8'h30;
    localparam logic [BYTE_W-1:0] EIGHT_HEADS = 8'h08;
    localparam int                LBA_BIT     = 6;

    // Register reset values.
    localparam logic [BYTE_W-1:0]    DRIVE_PREFIX_RST = 8'hA0;
    localparam logic [BYTE_W-1:0]    PRECOMP_RST      = 8'h00;
    localparam logic [HEADS_W-1:0]   HEAD_COUNT_RST   = 5'd16;
    localparam logic [BYTE_W-1:0]    SPT_RST          = 8'd63;
    localparam logic [PER_CYL_W-1:0] PER_CYL_RST      = 13'd1008;

    // Register indexes on the configuration channel.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIVE_PREFIX = 2'd0,
        CFG_PRECOMP      = 2'd1,
        CFG_HEAD_COUNT   = 2'd2,
        CFG_SPT          = 2'd3
    } cfg_reg_t;

endpackage

/* src/atatf_divider.sv */
// Pipelined restoring divider, one quotient bit per register stage.
module atatf_divider #(
    parameter int DVD_W  = 32,
    parameter int DIV_W  = 13,
    parameter int QUO_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DIV_W-1:0]  divisor,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quotient,
    output logic [DIV_W-1:0]  remainder,
    output logic [SIDE_W-1:0] side_out
);

    // Stage registers; stage i resolves quotient bit QUO_W-1-i.
    logic              valid_reg [QUO_W];
    logic [DIV_W-1:0]  rem_reg   [QUO_W];
    logic [QUO_W-1:0]  quo_reg   [QUO_W];
    logic [QUO_W-1:0]  bits_reg  [QUO_W];
    logic [DIV_W-1:0]  div_reg   [QUO_W];
    logic [SIDE_W-1:0] side_reg  [QUO_W];

    genvar i;
    generate
        for (i = 0; i < QUO_W; i++) begin : g_stage
            logic              prev_valid;
            logic [DIV_W-1:0]  prev_rem;
            logic [QUO_W-1:0]  prev_quo;
            logic [QUO_W-1:0]  prev_bits;
            logic [DIV_W-1:0]  prev_div;
            logic [SIDE_W-1:0] prev_side;
            logic [DIV_W:0]    trial;
            logic [DIV_W:0]    diff;
            logic              ge;
            logic [DIV_W-1:0]  rem_next;

            // The first stage starts from the dividend bits above the quotient,
            // which the caller keeps below the divisor.
            if (i == 0) begin : g_first
                assign prev_valid = in_valid;
                assign prev_rem   = DIV_W'(dividend >> QUO_W);
                assign prev_quo   = '0;
                assign prev_bits  = dividend[QUO_W-1:0];
                assign prev_div   = divisor;
                assign prev_side  = side_in;
            end else begin : g_next
                assign prev_valid = valid_reg[i-1];
                assign prev_rem   = rem_reg[i-1];
                assign prev_quo   = quo_reg[i-1];
                assign prev_bits  = bits_reg[i-1];
                assign prev_div   = div_reg[i-1];
                assign prev_side  = side_reg[i-1];
            end

            // One compare and subtract on the shifted partial remainder.
            assign trial    = {prev_rem, prev_bits[QUO_W-1]};
            assign diff     = trial - {1'b0, prev_div};
            assign ge       = (trial >= {1'b0, prev_div});
            assign rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[i] <= 1'b0;
                end else if (en) begin
                    valid_reg[i] <= prev_valid;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i]  <= rem_next;
                    quo_reg[i]  <= (prev_quo << 1) | QUO_W'(ge);
                    bits_reg[i] <= prev_bits << 1;
                    div_reg[i]  <= prev_div;
                    side_reg[i] <= prev_side;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[QUO_W-1];
    assign quotient  = quo_reg[QUO_W-1];
    assign remainder = rem_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];

endmodule

/* src/ata_taskfile_command_builder.sv */
// Top level: builds ATA task-file bytes from a sector request, in LBA or CHS form.
// A request passes through one input stage, a 32-stage
// cylinder divider, a 5-stage head divider and one output register.
// Throughput is one request per cycle; the whole pipeline stalls together while
// a result waits on m_tready. The divider stages make up most of the latency.
// Reset (aresetn low, synchronous) empties the pipeline and loads register defaults.
module ata_taskfile_command_builder #(
    parameter int MAX_SECTORS = atatf_pkg::MAX_SECTORS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Request channel.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [31:0] start_sector, [40:32] sector_total, [47:41] zero
    input  logic [atatf_pkg::S_TDATA_W-1:0]       s_tdata,
    // [0] is_write
    input  logic                                  s_tuser,
    // Result channel.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [7:0] precomp_byte, [15:8] count_byte, [23:16] sector_byte,
    // [31:24] cyl_low_byte, [39:32] cyl_high_byte, [47:40] drive_head_byte,
    // [55:48] command_byte, [63:56] control_byte, [64] cylinder_overflow,
    // [71:65] zero
    output logic [atatf_pkg::M_TDATA_W-1:0]       m_tdata,
    // Configuration write channel.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [atatf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [atatf_pkg::BYTE_W-1:0]          cfg_data
);

    localparam int SIDE1_W = atatf_pkg::BYTE_W + 1 + 28;
    localparam int SIDE2_W = SIDE1_W + 16 + 1;
    localparam logic [atatf_pkg::TOTAL_W-1:0] MAX_TOTAL = atatf_pkg::TOTAL_W'(MAX_SECTORS);

    // Configuration registers.
    logic [atatf_pkg::BYTE_W-1:0]    drive_prefix_reg, drive_prefix_next;
    logic [atatf_pkg::BYTE_W-1:0]    precomp_reg, precomp_next;
    logic [atatf_pkg::HEADS_W-1:0]   head_count_reg, head_count_next;
    logic [atatf_pkg::BYTE_W-1:0]    spt_reg, spt_next;
    logic [atatf_pkg::PER_CYL_W-1:0] per_cyl_reg, per_cyl_next;
    logic [atatf_pkg::HEADS_W-1:0]   heads_eff, heads_eff_next;
    logic [atatf_pkg::BYTE_W-1:0]    spt_eff, spt_eff_next;

    assign cfg_ready = 1'b1;

    // Register writes; the sectors-per-cylinder product follows the new geometry.
    always_comb begin
        drive_prefix_next = drive_prefix_reg;
        precomp_next      = precomp_reg;
        head_count_next   = head_count_reg;
        spt_next          = spt_reg;
        if (cfg_valid) begin
            case (atatf_pkg::cfg_reg_t'(cfg_index))
                atatf_pkg::CFG_DRIVE_PREFIX: drive_prefix_next = cfg_data;
                atatf_pkg::CFG_PRECOMP:      precomp_next      = cfg_data;
                atatf_pkg::CFG_HEAD_COUNT:   head_count_next   = cfg_data[atatf_pkg::HEADS_W-1:0];
                atatf_pkg::CFG_SPT:          spt_next          = cfg_data;
                default: ;
            endcase
        end
        heads_eff_next = (head_count_next == '0) ? atatf_pkg::HEADS_W'(1) : head_count_next;
        spt_eff_next   = (spt_next == '0) ? atatf_pkg::BYTE_W'(1) : spt_next;
        per_cyl_next   = {{atatf_pkg::BYTE_W{1'b0}}, heads_eff_next}
                       * {{atatf_pkg::HEADS_W{1'b0}}, spt_eff_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_prefix_reg <= atatf_pkg::DRIVE_PREFIX_RST;
            precomp_reg      <= atatf_pkg::PRECOMP_RST;
            head_count_reg   <= atatf_pkg::HEAD_COUNT_RST;
            spt_reg          <= atatf_pkg::SPT_RST;
            per_cyl_reg      <= atatf_pkg::PER_CYL_RST;
        end else begin
            drive_prefix_reg <= drive_prefix_next;
            precomp_reg      <= precomp_next;
            head_count_reg   <= head_count_next;
            spt_reg          <= spt_next;
            per_cyl_reg      <= per_cyl_next;
        end
    end

    assign heads_eff = (head_count_reg == '0) ? atatf_pkg::HEADS_W'(1) : head_count_reg;
    assign spt_eff   = (spt_reg == '0) ? atatf_pkg::BYTE_W'(1) : spt_reg;

    // The whole pipeline moves when the output register is free or being taken.
    logic adv;
    logic m_tvalid_reg;
    logic [atatf_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // Input stage: capture the request and saturate the sector total.
    logic                           a_valid_reg;
    logic [atatf_pkg::BLK_W-1:0]    a_blk_reg;
    logic [atatf_pkg::BYTE_W-1:0]   a_count_reg, a_count_next;
    logic                           a_wr_reg;
    logic [atatf_pkg::TOTAL_W-1:0]  in_total;

    assign in_total     = s_tdata[40:32];
    assign a_count_next = (in_total > MAX_TOTAL) ? MAX_TOTAL[atatf_pkg::BYTE_W-1:0]
                                                 : in_total[atatf_pkg::BYTE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_blk_reg   <= s_tdata[31:0];
            a_count_reg <= a_count_next;
            a_wr_reg    <= s_tuser;
        end
    end

    // Cylinder division: start sector by sectors per cylinder.
    logic                            d1_valid;
    logic [atatf_pkg::BLK_W-1:0]     d1_cyl;
    logic [atatf_pkg::PER_CYL_W-1:0] d1_rem;
    logic [SIDE1_W-1:0]              d1_side;

    atatf_divider #(
        .DVD_W  (atatf_pkg::BLK_W),
        .DIV_W  (atatf_pkg::PER_CYL_W),
        .QUO_W  (atatf_pkg::BLK_W),
        .SIDE_W (SIDE1_W)
    ) u_cyl_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (a_valid_reg),
        .dividend  (a_blk_reg),
        .divisor   (per_cyl_reg),
        .side_in   ({a_count_reg, a_wr_reg, a_blk_reg[27:0]}),
        .out_valid (d1_valid),
        .quotient  (d1_cyl),
        .remainder (d1_rem),
        .side_out  (d1_side)
    );

    // Head division: remainder within the cylinder by sectors per track.
    logic                            d2_valid;
    logic [atatf_pkg::HEADS_W-1:0]   d2_head;
    logic [atatf_pkg::BYTE_W-1:0]    d2_sec;
    logic [SIDE2_W-1:0]              d2_side;
    logic                            d1_ovf;

    assign d1_ovf = (d1_cyl[31:16] != '0);

    atatf_divider #(
        .DVD_W  (atatf_pkg::PER_CYL_W),
        .DIV_W  (atatf_pkg::BYTE_W),
        .QUO_W  (atatf_pkg::HEADS_W),
        .SIDE_W (SIDE2_W)
    ) u_head_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (d1_valid),
        .dividend  (d1_rem),
        .divisor   (spt_eff),
        .side_in   ({d1_side, d1_cyl[15:0], d1_ovf}),
        .out_valid (d2_valid),
        .quotient  (d2_head),
        .remainder (d2_sec),
        .side_out  (d2_side)
    );

    // Output stage: pick LBA or CHS bytes and pack the result.
    logic [atatf_pkg::BYTE_W-1:0] o_count, o_sec, o_clo, o_chi, o_ldh, o_cmd, o_ctl;
    logic [27:0]                  o_lba;
    logic [15:0]                  o_cyl;
    logic                         o_wr, o_ovf, lba_mode;

    assign lba_mode = drive_prefix_reg[atatf_pkg::LBA_BIT];

    always_comb begin
        o_count = d2_side[SIDE2_W-1 -: atatf_pkg::BYTE_W];
        o_wr    = d2_side[SIDE2_W-1-atatf_pkg::BYTE_W];
        o_lba   = d2_side[44:17];
        o_cyl   = d2_side[16:1];
        o_ovf   = d2_side[0];
        if (lba_mode) begin
            o_sec = o_lba[7:0];
            o_clo = o_lba[15:8];
            o_chi = o_lba[23:16];
            o_ldh = drive_prefix_reg | {4'b0, o_lba[27:24]};
            o_ovf = 1'b0;
        end else begin
            o_sec = d2_sec + atatf_pkg::BYTE_W'(1);
            o_clo = o_cyl[7:0];
            o_chi = o_cyl[15:8];
            o_ldh = drive_prefix_reg | {3'b0, d2_head};
        end
        o_cmd = o_wr ? atatf_pkg::OP_WRITE : atatf_pkg::OP_READ;
        o_ctl = (heads_eff >= atatf_pkg::HEADS_W'(8)) ? atatf_pkg::EIGHT_HEADS
                                                       : atatf_pkg::BYTE_W'(0);
        m_tdata_next = {7'b0, o_ovf, o_ctl, o_cmd, o_ldh, o_chi, o_clo, o_sec,
                        o_count, precomp_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The head number never reaches the head count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        d2_valid |-> (d2_head < heads_eff))
        else $error("head quotient not below head count");

    // An LBA result never reports a cylinder overflow.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && lba_mode) |-> !m_tdata[64])
        else $error("overflow flagged in LBA mode");

    // A CHS sector number is counted from one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !lba_mode) |-> (m_tdata[23:16] != 8'h00))
        else $error("CHS sector byte is zero");

    // A result that leaves the divider reaches the output register when the pipe moves.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (d2_valid && adv) |=> m_tvalid)
        else $error("result lost at output stage");

endmodule
